### sv/assert_macros.svh
// Assertion macros for the infix-to-postfix converter.
// Included by files that carry concurrent assertions; depends on clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define I2P_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p assertion failed");

// Next-cycle implication, disabled while in reset
`define I2P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p assertion failed");

`endif

### sv/i2p_pkg.sv
// Shared types, constants and symbol helpers for the infix-to-postfix converter.
// No dependencies.
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_LPAREN = 8'h28;
    localparam logic [7:0] SYM_RPAREN = 8'h29;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_TIMES  = 8'h2A;
    localparam logic [7:0] SYM_DIVIDE = 8'h2F;
    localparam logic [7:0] SYM_POWER  = 8'h5E;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expression;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       last_of_run;
        logic       expression_done;
    } out_item_t;

    // Shift command for the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } stk_op_t;

    // Stack status seen by the controller
    typedef struct packed {
        logic [7:0] top;
        logic       empty;
        logic       full;
    } stk_stat_t;

    typedef enum logic [1:0] {
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_OPER,
        KIND_OTHER
    } kind_t;

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == SYM_PLUS || c == SYM_MINUS) begin
            r = 2'd1;
        end
        else if (c == SYM_TIMES || c == SYM_DIVIDE) begin
            r = 2'd2;
        end
        else if (c == SYM_POWER) begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        if (c == SYM_LPAREN) begin
            k = KIND_LPAREN;
        end
        else if (c == SYM_RPAREN) begin
            k = KIND_RPAREN;
        end
        else if (rank_of(c) != 2'd0) begin
            k = KIND_OPER;
        end
        else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

### sv/infix_to_postfix_converter.sv
// Infix to postfix converter: top level with the shunting-yard sequencer.
// Depends on i2p_pkg, i2p_stack (and i2p_cell), and assert_macros.svh.
//
// The block takes one infix character per item and returns its postfix form
// as a stream of characters. Operators + - * / ^ rank 1, 1, 2, 2, 3, all
// left-associative; '(' is stacked, ')' unwinds down to the matching '(' and
// drops it, and every other byte passes straight through. The item flagged
// end_of_expression also flushes the operator stack. The stack is a chain of
// 32 shifting cells, so a push or a pop is one shift and the top is always in
// the first cell. One item is worked on at a time: it is taken in, pops the
// stack entries it must, takes one closing step (the push, the discarded '('
// or the pass-through character) and then has the last character of its run
// flagged; the final item of an expression first flushes the stack until it
// finds it empty. Steps that emit or flag a character wait while res_stall
// holds results back. Each result runs through a one-entry hold register (so
// the last character of a run can be flagged) and then the output register,
// so one result can wait in each while res_stall is high before the sequencer
// has to stall. A push onto a full stack is dropped. The stack has no reset
// sweep: only entries below the fill count are ever read.
`include "assert_macros.svh"

module infix_to_postfix_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_stall,
    input  i2p_pkg::in_item_t  sym_item,
    output logic               res_valid,
    input  logic               res_stall,
    output i2p_pkg::out_item_t res_item
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WORK   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;

    // Latched item
    logic [7:0]          sym_reg;
    logic                last_reg;
    i2p_pkg::kind_t      kind_reg;

    // Hold stage: the most recent character of the run, not yet flagged
    logic                hold_valid_reg;
    logic                hold_valid_next;
    logic [7:0]          hold_sym_reg;
    logic [7:0]          hold_sym_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    i2p_pkg::out_item_t  out_item_reg;
    i2p_pkg::out_item_t  out_item_next;

    i2p_pkg::stk_op_t    stk_op;
    i2p_pkg::stk_stat_t  stk_stat;

    logic                accept;
    logic                out_free;
    logic                can_emit;
    logic                emit;
    logic [7:0]          emit_sym;
    logic                release_hold;
    logic                step_done;

    assign sym_stall = (state_reg != S_IDLE);
    assign accept    = sym_valid && !sym_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    // A new character may enter the hold only if the old one can move on
    assign can_emit  = !hold_valid_reg || out_free;

    i2p_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (stk_op),
        .push_sym (sym_reg),
        .stat     (stk_stat)
    );

    // Sequencer: at most one stack action and one emitted character per cycle; an emit waits while can_emit is low
    always_comb begin
        state_next   = state_reg;
        stk_op.push  = 1'b0;
        stk_op.pop   = 1'b0;
        emit         = 1'b0;
        emit_sym     = stk_stat.top;
        release_hold = 1'b0;
        step_done    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_WORK;
                end
            end
            S_WORK: begin
                case (kind_reg)
                    i2p_pkg::KIND_LPAREN: begin
                        stk_op.push = 1'b1;
                        step_done   = 1'b1;
                    end
                    i2p_pkg::KIND_OPER: begin
                        // Pop while the top ranks at least as high, then push
                        if (!stk_stat.empty &&
                            (i2p_pkg::rank_of(sym_reg) <= i2p_pkg::rank_of(stk_stat.top))) begin
                            if (can_emit) begin
                                emit       = 1'b1;
                                stk_op.pop = 1'b1;
                            end
                        end
                        else begin
                            stk_op.push = 1'b1;
                            step_done   = 1'b1;
                        end
                    end
                    i2p_pkg::KIND_RPAREN: begin
                        // Unwind down to '(' and drop it; stop on an empty stack
                        if (!stk_stat.empty && (stk_stat.top != i2p_pkg::SYM_LPAREN)) begin
                            if (can_emit) begin
                                emit       = 1'b1;
                                stk_op.pop = 1'b1;
                            end
                        end
                        else begin
                            stk_op.pop = !stk_stat.empty;
                            step_done  = 1'b1;
                        end
                    end
                    default: begin
                        // Operand or any other byte: pass through
                        emit_sym = sym_reg;
                        if (can_emit) begin
                            emit      = 1'b1;
                            step_done = 1'b1;
                        end
                    end
                endcase
                if (step_done) begin
                    state_next = last_reg ? S_FLUSH : S_FINISH;
                end
            end
            S_FLUSH: begin
                if (!stk_stat.empty) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        stk_op.pop = 1'b1;
                    end
                end
                else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // Flag the held character as the end of this item's run
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end
                else if (out_free) begin
                    release_hold = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold and output register movement
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_item_next   = out_item_reg;

        if (emit) begin
            if (hold_valid_reg) begin
                out_valid_next                = 1'b1;
                out_item_next.out_symbol      = hold_sym_reg;
                out_item_next.last_of_run     = 1'b0;
                out_item_next.expression_done = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_sym_next   = emit_sym;
        end
        else if (release_hold) begin
            out_valid_next                = 1'b1;
            out_item_next.out_symbol      = hold_sym_reg;
            out_item_next.last_of_run     = 1'b1;
            out_item_next.expression_done = last_reg;
            hold_valid_next               = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        hold_sym_reg <= hold_sym_next;
        out_item_reg <= out_item_next;
        if (accept) begin
            sym_reg  <= sym_item.symbol;
            last_reg <= sym_item.end_of_expression;
            kind_reg <= i2p_pkg::classify(sym_item.symbol);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    // Every run is closed out before the next item is taken
    `I2P_ASSERT_NOW(a_idle_hold_empty, state_reg == S_IDLE, !hold_valid_reg)
    // The sequencer never pops an empty stack
    `I2P_ASSERT_NOW(a_no_pop_empty, stk_op.pop, !stk_stat.empty)
    // An accepted item always starts work in the next cycle
    `I2P_ASSERT_NEXT(a_accept_work, accept, state_reg == S_WORK)
    // The end of an expression is always the end of a run
    `I2P_ASSERT_NOW(a_done_is_last, res_valid && res_item.expression_done, res_item.last_of_run)

endmodule

### sv/i2p_cell.sv
// One cell of the operator stack chain: holds a single entry.
// Depends on i2p_pkg (stk_op_t).
module i2p_cell (
    input  logic             clk,
    input  i2p_pkg::stk_op_t op,
    input  logic [7:0]       upper,
    input  logic [7:0]       lower,
    output logic [7:0]       data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Take the entry above on a push, the entry below on a pop, else hold
    always_comb begin
        data_next = data_reg;
        if (op.push) begin
            data_next = upper;
        end
        else if (op.pop) begin
            data_next = lower;
        end
    end

    always_ff @(posedge clk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/i2p_stack.sv
// Operator stack built as a chain of shifting cells, top of stack in cell 0.
// Depends on i2p_pkg and i2p_cell.
module i2p_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  i2p_pkg::stk_op_t   op,
    input  logic [7:0]         push_sym,
    output i2p_pkg::stk_stat_t stat
);

    logic [i2p_pkg::CNT_W-1:0] count_reg;
    logic [i2p_pkg::CNT_W-1:0] count_next;
    logic [7:0]                cell_data [i2p_pkg::STACK_DEPTH];
    logic                      full;
    i2p_pkg::stk_op_t          cell_op;

    assign full = (count_reg == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));

    // Drop a push onto a full stack: do not shift at all
    always_comb begin
        cell_op.push = op.push && !full;
        cell_op.pop  = op.pop && (count_reg != '0);
    end

    always_comb begin
        count_next = count_reg;
        if (cell_op.push) begin
            count_next = count_reg + 1'b1;
        end
        else if (cell_op.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < i2p_pkg::STACK_DEPTH; i++) begin : g_cell
        logic [7:0] upper;
        logic [7:0] lower;
        if (i == 0) begin : g_top
            assign upper = push_sym;
        end
        else begin : g_mid
            assign upper = cell_data[i-1];
        end
        if (i == i2p_pkg::STACK_DEPTH - 1) begin : g_bottom
            assign lower = cell_data[i];
        end
        else begin : g_above
            assign lower = cell_data[i+1];
        end
        i2p_cell u_cell (
            .clk   (clk),
            .op    (cell_op),
            .upper (upper),
            .lower (lower),
            .data  (cell_data[i])
        );
    end

    always_comb begin
        stat.top   = cell_data[0];
        stat.empty = (count_reg == '0);
        stat.full  = full;
    end

endmodule
